[design/fdc_pkg.sv]
package fdc_pkg;

    localparam int MAX_DATAGRAM = 65536;
    localparam int OFF_W        = $clog2(MAX_DATAGRAM + 1);

    localparam logic [7:0] MARK_A = 8'h7f;
    localparam logic [7:0] MARK_B = 8'hf7;

    localparam logic [OFF_W-1:0] OFF_START_B   = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_VER_LO    = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_VER_HI    = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_INSTR     = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFF_SOURCE    = OFF_W'(7);
    localparam logic [OFF_W-1:0] OFF_CMD_LO    = OFF_W'(8);
    localparam logic [OFF_W-1:0] OFF_CMD_HI    = OFF_W'(9);
    localparam logic [OFF_W-1:0] OFF_CMD_TYPE  = OFF_W'(10);
    localparam logic [OFF_W-1:0] OFF_LEN0      = OFF_W'(11);
    localparam logic [OFF_W-1:0] OFF_LEN1      = OFF_W'(12);
    localparam logic [OFF_W-1:0] OFF_LEN2      = OFF_W'(13);
    localparam logic [OFF_W-1:0] OFF_LEN3      = OFF_W'(14);
    localparam logic [OFF_W-1:0] OFF_PAYLOAD   = OFF_W'(15);
    localparam logic [OFF_W-1:0] OFF_CNT_LIMIT = OFF_W'(MAX_DATAGRAM);

    localparam int FRAME_OVERHEAD = 21;

    localparam int M_TDATA_W = 88;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MARKER   = 3'd1,
        ST_VERSION  = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_LENGTH   = 3'd4
    } fdc_status_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  payload_byte;
        fdc_status_t status;
        logic [7:0]  instruction;
        logic [7:0]  sender_id;
        logic [7:0]  command_id_low;
        logic [7:0]  command_id_high;
        logic [7:0]  command_type;
        logic [31:0] payload_length;
    } fdc_result_t;

endpackage

[design/fdc_core.sv]
module fdc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [7:0]           rx_byte,
    input  logic                 end_of_datagram,
    input  logic [15:0]          expected_version,
    output fdc_pkg::fdc_result_t res
);

    logic [fdc_pkg::OFF_W-1:0] off_reg, off_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  prev_reg, prev_next;
    logic        start_ok_reg, start_ok_next;
    logic [15:0] ver_reg, ver_next;
    logic [7:0]  instr_reg, instr_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  cid_lo_reg, cid_lo_next;
    logic [7:0]  cid_hi_reg, cid_hi_next;
    logic [7:0]  ctype_reg, ctype_next;
    logic [31:0] len_reg, len_next;

    logic        counted;
    logic        payload_hit;
    logic [fdc_pkg::OFF_W-1:0] pay_off;
    logic [fdc_pkg::OFF_W:0]   total;
    logic [32:0] need;
    logic [7:0]  check;
    fdc_pkg::fdc_status_t st;

    always_comb begin
        counted = (off_reg < fdc_pkg::OFF_CNT_LIMIT);

        start_ok_next = start_ok_reg;
        ver_next      = ver_reg;
        instr_next    = instr_reg;
        src_next      = src_reg;
        cid_lo_next   = cid_lo_reg;
        cid_hi_next   = cid_hi_reg;
        ctype_next    = ctype_reg;
        len_next      = len_reg;

        if (counted) begin
            case (off_reg)
                fdc_pkg::OFF_START_B: begin
                    start_ok_next = (prev_reg == fdc_pkg::MARK_A) && (rx_byte == fdc_pkg::MARK_B);
                end
                fdc_pkg::OFF_VER_LO:   ver_next = {8'h00, rx_byte};
                fdc_pkg::OFF_VER_HI:   ver_next = {rx_byte, ver_reg[7:0]};
                fdc_pkg::OFF_INSTR:    instr_next = rx_byte;
                fdc_pkg::OFF_SOURCE:   src_next = rx_byte;
                fdc_pkg::OFF_CMD_LO:   cid_lo_next = rx_byte;
                fdc_pkg::OFF_CMD_HI:   cid_hi_next = rx_byte;
                fdc_pkg::OFF_CMD_TYPE: ctype_next = rx_byte;
                fdc_pkg::OFF_LEN0:     len_next = {len_reg[31:8], rx_byte};
                fdc_pkg::OFF_LEN1:     len_next = {len_reg[31:16], rx_byte, len_reg[7:0]};
                fdc_pkg::OFF_LEN2:     len_next = {len_reg[31:24], rx_byte, len_reg[15:0]};
                fdc_pkg::OFF_LEN3:     len_next = {rx_byte, len_reg[23:0]};
                default: begin
                end
            endcase
        end

        pay_off     = off_reg - fdc_pkg::OFF_PAYLOAD;
        payload_hit = counted && (off_reg >= fdc_pkg::OFF_PAYLOAD) &&
                      (32'(pay_off) < len_reg);

        total = {1'b0, off_reg} + (fdc_pkg::OFF_W+1)'(1);
        need  = {1'b0, len_next} + 33'(fdc_pkg::FRAME_OVERHEAD);
        check = sum_reg - prev_reg + 8'd1;

        if (!counted) begin
            st = fdc_pkg::ST_LENGTH;
        end else if (off_reg < fdc_pkg::OFF_VER_HI || !start_ok_next ||
                     prev_reg != fdc_pkg::MARK_B || rx_byte != fdc_pkg::MARK_A) begin
            st = fdc_pkg::ST_MARKER;
        end else if (ver_next != expected_version) begin
            st = fdc_pkg::ST_VERSION;
        end else if (check != 8'd0) begin
            st = fdc_pkg::ST_CHECKSUM;
        end else if (need > 33'(total)) begin
            st = fdc_pkg::ST_LENGTH;
        end else begin
            st = fdc_pkg::ST_OK;
        end

        res = '0;
        if (end_of_datagram) begin
            res.valid           = 1'b1;
            res.kind            = 1'b1;
            res.status          = st;
            res.instruction     = instr_next;
            res.sender_id       = src_next;
            res.command_id_low  = cid_lo_next;
            res.command_id_high = cid_hi_next;
            res.command_type    = ctype_next;
            res.payload_length  = len_next;
        end else if (payload_hit) begin
            res.valid        = 1'b1;
            res.payload_byte = rx_byte;
        end

        if (end_of_datagram) begin
            off_next      = '0;
            sum_next      = '0;
            prev_next     = '0;
            start_ok_next = 1'b0;
            ver_next      = '0;
            instr_next    = '0;
            src_next      = '0;
            cid_lo_next   = '0;
            cid_hi_next   = '0;
            ctype_next    = '0;
            len_next      = '0;
        end else begin
            off_next  = counted ? off_reg + fdc_pkg::OFF_W'(1) : off_reg;
            sum_next  = (off_reg >= fdc_pkg::OFF_VER_LO) ? sum_reg + rx_byte : sum_reg;
            prev_next = rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg      <= '0;
            sum_reg      <= '0;
            prev_reg     <= '0;
            start_ok_reg <= 1'b0;
            ver_reg      <= '0;
            instr_reg    <= '0;
            src_reg      <= '0;
            cid_lo_reg   <= '0;
            cid_hi_reg   <= '0;
            ctype_reg    <= '0;
            len_reg      <= '0;
        end else if (en) begin
            off_reg      <= off_next;
            sum_reg      <= sum_next;
            prev_reg     <= prev_next;
            start_ok_reg <= start_ok_next;
            ver_reg      <= ver_next;
            instr_reg    <= instr_next;
            src_reg      <= src_next;
            cid_lo_reg   <= cid_lo_next;
            cid_hi_reg   <= cid_hi_next;
            ctype_reg    <= ctype_next;
            len_reg      <= len_next;
        end
    end

endmodule

[design/frame_deframer_checksum_top.sv]
// Channel   Dir  Handshake         Payload
// s_        in   tvalid/tready     tdata[7:0] rx_byte, tlast end_of_datagram
// m_        out  tvalid/tready     tdata[82:0] result fields, tuser kind
// cfg_      in   wr_en             wr_data[15:0] expected_version
//
// One item per cycle sustained while m_tready is high; a result passes through the
// input register, then frame logic into the result register.
// Reset clears the frame state, both stage valids and sets expected_version to 1.
// A stall on m_tready holds the result register and then the input register;
// an input item that yields no result still waits for a free result slot.
module frame_deframer_checksum_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [10:8] status, [18:11] instruction, [26:19] sender_id,
    // [34:27] command_id_low, [42:35] command_id_high, [50:43] command_type,
    // [82:51] payload_length, [87:83] zero
    output logic [fdc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tuser,  // [0] kind
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [15:0] ver_cfg_reg;
    logic        advance;
    fdc_pkg::fdc_result_t res;
    fdc_pkg::fdc_result_t out_reg;
    logic        out_valid_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_cfg_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            ver_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fdc_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (in_valid_reg && advance),
        .rx_byte          (in_byte_reg),
        .end_of_datagram  (in_last_reg),
        .expected_version (ver_cfg_reg),
        .res              (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.payload_length, out_reg.command_type,
                       out_reg.command_id_high, out_reg.command_id_low,
                       out_reg.sender_id, out_reg.instruction,
                       3'(out_reg.status), out_reg.payload_byte};

endmodule

[design/fdc_checker.sv]
module fdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [fdc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[fdc_pkg::M_TDATA_W-1:8] == '0)
        else $error("payload item carries header or status bits");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 &&
            (m_tdata[10:8] == 3'(fdc_pkg::ST_OK) || m_tdata[10:8] == 3'(fdc_pkg::ST_MARKER) ||
             m_tdata[10:8] == 3'(fdc_pkg::ST_VERSION) ||
             m_tdata[10:8] == 3'(fdc_pkg::ST_CHECKSUM) ||
             m_tdata[10:8] == 3'(fdc_pkg::ST_LENGTH)))
        else $error("status item malformed");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind frame_deframer_checksum_top fdc_checker u_fdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
